### hw/rtl/lla_pkg.sv
package lla_pkg;

  // default grid size
  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 64;

  // field and register widths
  localparam int OP_W       = 2;
  localparam int POS_W      = 6;
  localparam int SIZE_W     = 7;
  localparam int MASK_W     = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // operation codes
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ    = 2'd1;
  localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_EDGES    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIRTH_MASK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SURVIVAL_MASK = 3'd4;

  // reset values, rule B3/S23 on the full grid
  localparam logic [SIZE_W-1:0] RST_GRID_WIDTH    = 7'd64;
  localparam logic [SIZE_W-1:0] RST_GRID_HEIGHT   = 7'd64;
  localparam logic              RST_WRAP_EDGES    = 1'b0;
  localparam logic [MASK_W-1:0] RST_BIRTH_MASK    = 9'd8;
  localparam logic [MASK_W-1:0] RST_SURVIVAL_MASK = 9'd12;

  // controls for the row update unit
  typedef struct packed {
    logic [SIZE_W-1:0] used_w;
    logic              wrap;
    logic              first_row;
    logic              last_row;
    logic [MASK_W-1:0] birth_mask;
    logic [MASK_W-1:0] survival_mask;
  } gen_ctl_t;

endpackage

### hw/rtl/lla_ram.sv
module lla_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/lla_row_unit.sv
module lla_row_unit #(
  parameter int MAX_COLS = lla_pkg::DEF_MAX_COLS
) (
  input  lla_pkg::gen_ctl_t    ctl,
  input  logic [MAX_COLS-1:0]  above,
  input  logic [MAX_COLS-1:0]  cur,
  input  logic [MAX_COLS-1:0]  below,
  output logic [MAX_COLS-1:0]  new_row
);

  localparam int CW = $clog2(MAX_COLS);

  // neighbour to the left of each column, wrapping column 0 to the last one
  function automatic logic [MAX_COLS-1:0] left_of(input logic [MAX_COLS-1:0] r,
                                                  input logic wrap,
                                                  input logic [CW-1:0] last);
    logic [MAX_COLS-1:0] v;
    v = r << 1;
    v[0] = wrap & r[last];
    return v;
  endfunction

  // neighbour to the right, the last column wraps to column 0
  function automatic logic [MAX_COLS-1:0] right_of(input logic [MAX_COLS-1:0] r,
                                                   input logic wrap,
                                                   input logic [CW-1:0] last);
    logic [MAX_COLS-1:0] v;
    v = r >> 1;
    v[last] = wrap & r[0];
    return v;
  endfunction

  logic [MAX_COLS-1:0] col_mask;
  logic [MAX_COLS-1:0] ra, rc, rb;
  logic [MAX_COLS-1:0] la, lc, lb, xa, xc, xb;
  logic [CW-1:0]       last_col;
  logic [3:0]          cnt;

  assign last_col = CW'(ctl.used_w - 7'd1);

  always_comb begin
    for (int x = 0; x < MAX_COLS; x++) begin
      col_mask[x] = (x < int'(ctl.used_w));
    end
    // outside rows count as dead unless wrapping
    ra = (!ctl.wrap && ctl.first_row) ? '0 : (above & col_mask);
    rc = cur & col_mask;
    rb = (!ctl.wrap && ctl.last_row) ? '0 : (below & col_mask);
    la = left_of(ra, ctl.wrap, last_col);
    lc = left_of(rc, ctl.wrap, last_col);
    lb = left_of(rb, ctl.wrap, last_col);
    xa = right_of(ra, ctl.wrap, last_col);
    xc = right_of(rc, ctl.wrap, last_col);
    xb = right_of(rb, ctl.wrap, last_col);
    cnt = '0;
    for (int x = 0; x < MAX_COLS; x++) begin
      cnt = 4'(la[x]) + 4'(ra[x]) + 4'(xa[x]) + 4'(lc[x]) + 4'(xc[x])
          + 4'(lb[x]) + 4'(rb[x]) + 4'(xb[x]);
      new_row[x] = col_mask[x] &
                   (rc[x] ? ctl.survival_mask[cnt] : ctl.birth_mask[cnt]);
    end
  end

endmodule

### hw/rtl/life_like_automaton_step_core.sv
// Life-like cellular automaton (B/S rule) on a MAX_ROWS x MAX_COLS bit grid held
// in one row-wide memory, of which the top-left grid_height x grid_width cells
// are in use. Each request writes a cell, reads a cell, clears the grid or
// advances one generation, and returns exactly one result (cell_out,
// out_of_range). Clear and any out-of-range read or write are answered straight
// from the idle state; an in-range read or write does a memory read, then a
// read-modify-write of the row. An advance sweeps every row in use: the single
// row-wide neighbour unit produces one new row per cycle, fed by one memory
// read per cycle, with the final fetch taken from a saved copy of row 0.
// The grid is empty right after reset with no clearing pass: each row carries
// a valid flag, and a row whose flag is low reads as all dead. Configuration
// writes are taken every cycle and must only be issued while the block is idle.
module life_like_automaton_step_core #(
  parameter int MAX_COLS = lla_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = lla_pkg::DEF_MAX_ROWS
) (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lla_pkg::OP_W-1:0]       op,
  input  logic [lla_pkg::POS_W-1:0]      col,
  input  logic [lla_pkg::POS_W-1:0]      row,
  input  logic                           cell_in,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           cell_out,
  output logic                           out_of_range,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lla_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int SW = $clog2(MAX_ROWS + 2);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CELL = 2'd1;
  localparam logic [1:0] S_GEN  = 2'd2;

  logic [1:0] state;

  // configuration registers
  logic [lla_pkg::SIZE_W-1:0] grid_width;
  logic [lla_pkg::SIZE_W-1:0] grid_height;
  logic                       wrap_edges;
  logic [lla_pkg::MASK_W-1:0] birth_mask;
  logic [lla_pkg::MASK_W-1:0] survival_mask;

  // size in use, zero acts as one and anything above the maximum is clamped
  logic [lla_pkg::SIZE_W-1:0] used_w, used_h;

  always_comb begin
    used_w = grid_width;
    if (grid_width == '0) used_w = 7'd1;
    else if (int'(grid_width) > MAX_COLS) used_w = lla_pkg::SIZE_W'(MAX_COLS);
    used_h = grid_height;
    if (grid_height == '0) used_h = 7'd1;
    else if (int'(grid_height) > MAX_ROWS) used_h = lla_pkg::SIZE_W'(MAX_ROWS);
  end

  // one flag per row, a low flag means the row is all dead
  logic [MAX_ROWS-1:0] row_valid;

  // latched request
  logic [lla_pkg::OP_W-1:0]  req_op;
  logic [lla_pkg::POS_W-1:0] req_col;
  logic [lla_pkg::POS_W-1:0] req_row;
  logic                      req_cell;

  // grid memory ports
  logic                ram_we, ram_re;
  logic [RW-1:0]       ram_waddr, ram_raddr;
  logic [MAX_COLS-1:0] ram_wdata, ram_rdata;
  logic                rd_row_valid;
  logic [MAX_COLS-1:0] rd_row;

  // generation pipeline: issue step, data arrival, row compute and write back
  logic                issuing;
  logic [SW-1:0]       gstep;
  logic                a_valid;
  logic [SW-1:0]       a_step;
  logic                c_valid;
  logic [SW-1:0]       c_step;
  logic [MAX_COLS-1:0] above, cur, below, row0;
  logic [MAX_COLS-1:0] fetched;
  logic [MAX_COLS-1:0] new_row;
  logic [SW-1:0]       h_sw, step_end;
  logic [RW-1:0]       fetch_addr;
  logic                gen_done;
  lla_pkg::gen_ctl_t   gen_ctl;

  logic                in_fire;
  logic                in_grid;
  logic [MAX_COLS-1:0] cell_wdata;
  logic [CW-1:0]       col_idx;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign in_grid   = ({1'b0, col} < used_w) && ({1'b0, row} < used_h);

  // masked read data of the grid row that came back from memory
  assign rd_row = rd_row_valid ? ram_rdata : '0;

  // read-modify-write of one cell
  assign col_idx = CW'(req_col);
  always_comb begin
    cell_wdata = rd_row;
    cell_wdata[col_idx] = req_cell;
  end

  // fetch order: last row, rows 0..h-1, then row 0 again from its saved copy
  assign h_sw       = SW'(used_h);
  assign step_end   = h_sw + SW'(1);
  assign fetch_addr = (gstep == '0) ? RW'(h_sw - SW'(1)) : RW'(gstep - SW'(1));
  assign fetched    = (a_step == step_end) ? row0 : rd_row;
  assign gen_done   = (state == S_GEN) && c_valid && (c_step == step_end);

  // window holds rows y-1, y, y+1 for output row y = c_step - 2
  assign gen_ctl.used_w        = used_w;
  assign gen_ctl.wrap          = wrap_edges;
  assign gen_ctl.first_row     = (c_step == SW'(2));
  assign gen_ctl.last_row      = (c_step == step_end);
  assign gen_ctl.birth_mask    = birth_mask;
  assign gen_ctl.survival_mask = survival_mask;

  lla_row_unit #(
    .MAX_COLS (MAX_COLS)
  ) u_row_unit (
    .ctl     (gen_ctl),
    .above   (above),
    .cur     (cur),
    .below   (below),
    .new_row (new_row)
  );

  // memory port muxing between cell requests and the generation sweep
  assign ram_re    = (state == S_IDLE && in_fire) ||
                     (state == S_GEN && issuing && gstep != step_end);
  assign ram_raddr = (state == S_GEN) ? fetch_addr : RW'(row);
  assign ram_we    = (state == S_CELL && req_op == lla_pkg::OP_WRITE) ||
                     (state == S_GEN && c_valid && c_step >= SW'(2));
  assign ram_waddr = (state == S_GEN) ? RW'(c_step - SW'(2)) : RW'(req_row);
  assign ram_wdata = (state == S_GEN) ? new_row : cell_wdata;

  lla_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      cell_out      <= 1'b0;
      out_of_range  <= 1'b0;
      row_valid     <= '0;
      issuing       <= 1'b0;
      a_valid       <= 1'b0;
      c_valid       <= 1'b0;
      grid_width    <= lla_pkg::RST_GRID_WIDTH;
      grid_height   <= lla_pkg::RST_GRID_HEIGHT;
      wrap_edges    <= lla_pkg::RST_WRAP_EDGES;
      birth_mask    <= lla_pkg::RST_BIRTH_MASK;
      survival_mask <= lla_pkg::RST_SURVIVAL_MASK;
    end else begin
      // writes beyond the register list are dropped
      if (cfg_valid) begin
        case (cfg_index)
          lla_pkg::REG_GRID_WIDTH:    grid_width    <= cfg_data[lla_pkg::SIZE_W-1:0];
          lla_pkg::REG_GRID_HEIGHT:   grid_height   <= cfg_data[lla_pkg::SIZE_W-1:0];
          lla_pkg::REG_WRAP_EDGES:    wrap_edges    <= cfg_data[0];
          lla_pkg::REG_BIRTH_MASK:    birth_mask    <= cfg_data;
          lla_pkg::REG_SURVIVAL_MASK: survival_mask <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && out_ready) out_valid <= 1'b0;

      a_valid <= issuing;
      c_valid <= a_valid;
      if (issuing && gstep == step_end) issuing <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (op)
              lla_pkg::OP_WRITE, lla_pkg::OP_READ: begin
                if (!in_grid) begin
                  out_valid    <= 1'b1;
                  cell_out     <= 1'b0;
                  out_of_range <= 1'b1;
                end else begin
                  state <= S_CELL;
                end
              end
              lla_pkg::OP_ADVANCE: begin
                state   <= S_GEN;
                issuing <= 1'b1;
              end
              lla_pkg::OP_CLEAR: begin
                row_valid    <= '0;
                out_valid    <= 1'b1;
                cell_out     <= 1'b0;
                out_of_range <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_CELL: begin
          if (req_op == lla_pkg::OP_WRITE) row_valid[RW'(req_row)] <= 1'b1;
          out_valid    <= 1'b1;
          cell_out     <= (req_op == lla_pkg::OP_READ) ? rd_row[col_idx] : 1'b0;
          out_of_range <= 1'b0;
          state        <= S_IDLE;
        end
        S_GEN: begin
          if (gen_done) begin
            // every row in use was just rewritten, rows beyond it are now dead
            for (int i = 0; i < MAX_ROWS; i++) begin
              row_valid[i] <= (i < int'(used_h));
            end
            out_valid    <= 1'b1;
            cell_out     <= 1'b0;
            out_of_range <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_op   <= op;
      req_col  <= col;
      req_row  <= row;
      req_cell <= cell_in;
    end
    if (ram_re) rd_row_valid <= row_valid[ram_raddr];

    if (state == S_IDLE) gstep <= '0;
    else if (issuing) gstep <= gstep + SW'(1);

    a_step <= gstep;
    c_step <= a_step;

    // slide the three-row window as each fetched row lands
    if (a_valid) begin
      above <= cur;
      cur   <= below;
      below <= fetched;
      if (a_step == SW'(1)) row0 <= fetched;
    end
  end

endmodule

### hw/rtl/lla_checker.sv
module lla_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [lla_pkg::OP_W-1:0] op,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     cell_out,
  input logic                     out_of_range
);

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_out) && $stable(out_of_range))
    else $error("result changed while stalled");

  // clear answers in the next cycle with an all-zero result
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op == lla_pkg::OP_CLEAR |=>
      out_valid && !cell_out && !out_of_range)
    else $error("clear result missing or wrong");

  // an advance keeps the block busy rather than answering at once
  a_advance_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op == lla_pkg::OP_ADVANCE |=>
      !out_valid && !in_ready ##1 !out_valid)
    else $error("advance finished too early");

  // an out-of-range access never returns a live cell
  a_read_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && cell_out |-> !out_of_range)
    else $error("live cell reported out of range");

endmodule

bind life_like_automaton_step_core lla_checker u_lla_checker (.*);

### sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lla_pkg::*;

  // one request as driven on the request channel
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             cell_in;
  } cell_cmd_t;

  // one result as seen on the result channel
  typedef struct packed {
    logic cell_out;
    logic out_of_range;
  } cell_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [OP_W-1:0]       op = OP_READ;
  logic [POS_W-1:0]      col = '0;
  logic [POS_W-1:0]      row = '0;
  logic                  cell_in = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  cell_out;
  logic                  out_of_range;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_GRID_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #10 clk = ~clk;

  life_like_automaton_step_core uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .col          (col),
    .row          (row),
    .cell_in      (cell_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cell_out     (cell_out),
    .out_of_range (out_of_range),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // shadow copy of the grid and of the rule registers
  logic [DEF_MAX_COLS-1:0] live_rows [DEF_MAX_ROWS];
  logic [DEF_MAX_COLS-1:0] prior_rows [DEF_MAX_ROWS];
  logic [SIZE_W-1:0]       rule_width;
  logic [SIZE_W-1:0]       rule_height;
  logic                    rule_wrap;
  logic [MASK_W-1:0]       rule_birth;
  logic [MASK_W-1:0]       rule_survive;

  cell_cmd_t    cmd_queue [$];     // requests not yet on the bus
  cell_result_t due_results [$];   // results owed by the block, oldest first
  cell_cmd_t    drv_cmd;
  cell_result_t want;
  int           n_queued = 0;
  int           n_taken = 0;
  int           n_errors = 0;
  logic         req_fire = 1'b0;
  int           req_gap = 0;
  int           rsp_stall = 0;
  bit           quiet = 1'b0;

  // size register as the block uses it: zero acts as one, clamp at the maximum
  function automatic int span(logic [SIZE_W-1:0] sz, int lim);
    if (sz == 0) return 1;
    if (sz > lim) return lim;
    return int'(sz);
  endfunction

  // apply one request to the shadow grid and return the result it owes
  function automatic cell_result_t life_step(cell_cmd_t c);
    cell_result_t r;
    int w, h, n, nx, ny;
    r = '0;
    w = span(rule_width, DEF_MAX_COLS);
    h = span(rule_height, DEF_MAX_ROWS);
    case (c.op)
      OP_WRITE, OP_READ: begin
        if (c.col >= w || c.row >= h) begin
          r.out_of_range = 1'b1;
        end else if (c.op == OP_WRITE) begin
          live_rows[c.row][c.col] = c.cell_in;
        end else begin
          r.cell_out = live_rows[c.row][c.col];
        end
      end
      OP_ADVANCE: begin
        // snapshot first, everything outside the used area ends up dead
        prior_rows = live_rows;
        foreach (live_rows[i]) live_rows[i] = '0;
        for (int y = 0; y < h; y++) begin
          for (int x = 0; x < w; x++) begin
            n = 0;
            for (int dy = -1; dy <= 1; dy++) begin
              for (int dx = -1; dx <= 1; dx++) begin
                if (dx == 0 && dy == 0) continue;
                if (rule_wrap) begin
                  // plain modulo, so narrow tori may count a cell twice or itself
                  nx = (x + w + dx) % w;
                  ny = (y + h + dy) % h;
                  n += prior_rows[ny][nx];
                end else if (x + dx >= 0 && x + dx < w && y + dy >= 0 && y + dy < h) begin
                  n += prior_rows[y + dy][x + dx];
                end
              end
            end
            live_rows[y][x] = prior_rows[y][x] ? rule_survive[n] : rule_birth[n];
          end
        end
      end
      default: begin
        foreach (live_rows[i]) live_rows[i] = '0;
      end
    endcase
    return r;
  endfunction

  function automatic void queue_cmd(logic [OP_W-1:0] o, int c, int r, int v);
    cmd_queue.push_back(cell_cmd_t'{op: o, col: POS_W'(c), row: POS_W'(r), cell_in: v[0]});
    n_queued++;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_size();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return 1;
      2:       return 2;
      3:       return 64;
      4:       return $urandom_range(65, 511);  // upper bits dropped by the register
      default: return $urandom_range(3, 10);
    endcase
  endfunction

  function automatic int pick_mask(int usual);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 511;
      2:       return usual;
      default: return $urandom_range(0, 511);
    endcase
  endfunction

  // one round of stimulus: seed a patch, run a few generations, read around it
  function automatic void queue_phase();
    int w, h, pw, ph, x0, y0, rx0, rx1, ry0, ry1, n_wr, n_gen;
    w  = span(rule_width, DEF_MAX_COLS);
    h  = span(rule_height, DEF_MAX_ROWS);
    pw = (w < 10) ? w : 10;
    ph = (h < 10) ? h : 10;
    x0 = $urandom_range(0, w - pw);
    y0 = $urandom_range(0, h - ph);
    // the grid usually carries over from the last setting, sometimes not
    if ($urandom_range(0, 3) == 0)
      queue_cmd(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
    n_wr = $urandom_range(1, (pw * ph < 24) ? pw * ph : 24);
    for (int i = 0; i < n_wr; i++)
      queue_cmd(OP_WRITE, x0 + $urandom_range(0, pw - 1), y0 + $urandom_range(0, ph - 1),
                int'($urandom_range(0, 99) < 65));
    // write anywhere, often off the grid in use
    if ($urandom_range(0, 4) == 0)
      queue_cmd(OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 63), 1);
    rx0 = (x0 > 0) ? x0 - 1 : 0;
    rx1 = (x0 + pw < w) ? x0 + pw : w - 1;
    ry0 = (y0 > 0) ? y0 - 1 : 0;
    ry1 = (y0 + ph < h) ? y0 + ph : h - 1;
    n_gen = $urandom_range(1, 3);
    for (int g = 0; g < n_gen; g++) begin
      queue_cmd(OP_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
      if ((rx1 - rx0 + 1) * (ry1 - ry0 + 1) <= 16) begin
        for (int y = ry0; y <= ry1; y++)
          for (int x = rx0; x <= rx1; x++)
            queue_cmd(OP_READ, x, y, $urandom_range(0, 1));
      end else begin
        for (int i = 0; i < 12; i++)
          queue_cmd(OP_READ, $urandom_range(rx0, rx1), $urandom_range(ry0, ry1),
                    $urandom_range(0, 1));
      end
      queue_cmd(OP_READ, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
    end
    // a little noise with every field random
    repeat ($urandom_range(0, 3))
      queue_cmd(OP_W'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 63),
                $urandom_range(0, 1));
  endfunction

  // every request handed over and answered, then let the pipeline drain
  task automatic wait_idle();
    while (n_taken != n_queued || due_results.size() != 0) @(negedge clk);
    repeat (DEF_MAX_ROWS + 8) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'(val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    // shadow the register exactly as the block keeps it
    case (idx)
      REG_GRID_WIDTH:    rule_width   = d[SIZE_W-1:0];
      REG_GRID_HEIGHT:   rule_height  = d[SIZE_W-1:0];
      REG_WRAP_EDGES:    rule_wrap    = d[0];
      REG_BIRTH_MASK:    rule_birth   = d[MASK_W-1:0];
      REG_SURVIVAL_MASK: rule_survive = d[MASK_W-1:0];
      default: ;
    endcase
  endtask

  // registers only change with the block idle, so drain first
  task automatic set_config(int w, int h, int wr, int b, int s);
    wait_idle();
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    write_reg(REG_WRAP_EDGES, wr);
    write_reg(REG_BIRTH_MASK, b);
    write_reg(REG_SURVIVAL_MASK, s);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // request driver: new payload only once the previous request was taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_fire) begin
      if (req_gap > 0 || cmd_queue.size() == 0) begin
        in_valid <= 1'b0;
        if (req_gap > 0) req_gap--;
      end else begin
        drv_cmd = cmd_queue.pop_front();
        op       <= drv_cmd.op;
        col      <= drv_cmd.col;
        row      <= drv_cmd.row;
        cell_in  <= drv_cmd.cell_in;
        in_valid <= 1'b1;
        req_gap  = gap_len();
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rsp_stall > 0) begin
      out_ready <= 1'b0;
      rsp_stall--;
    end else begin
      out_ready <= 1'b1;
      rsp_stall = gap_len();
    end
  end

  // monitor: predict on every taken request, check every taken result
  always @(posedge clk) begin
    req_fire = !rst && in_valid && in_ready;
    if (req_fire) begin
      due_results.push_back(life_step(cell_cmd_t'{op, col, row, cell_in}));
      n_taken++;
    end
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        n_errors++;
        $error("result with no request outstanding: cell_out %0d out_of_range %0d",
               cell_out, out_of_range);
      end else begin
        want = due_results.pop_front();
        if (cell_out !== want.cell_out) begin
          n_errors++;
          $error("cell_out: expected %0d, got %0d", want.cell_out, cell_out);
        end
        if (out_of_range !== want.out_of_range) begin
          n_errors++;
          $error("out_of_range: expected %0d, got %0d", want.out_of_range, out_of_range);
        end
      end
    end
  end

  initial begin
    foreach (live_rows[i]) live_rows[i] = '0;
    foreach (prior_rows[i]) prior_rows[i] = '0;
    rule_width   = RST_GRID_WIDTH;
    rule_height  = RST_GRID_HEIGHT;
    rule_wrap    = RST_WRAP_EDGES;
    rule_birth   = RST_BIRTH_MASK;
    rule_survive = RST_SURVIVAL_MASK;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset rule B3/S23, full grid, dead edges
    queue_cmd(OP_READ, 0, 0, 1);          // fresh grid reads dead
    queue_cmd(OP_WRITE, 0, 0, 1);
    queue_cmd(OP_WRITE, 63, 63, 1);       // far corner
    queue_cmd(OP_READ, 63, 63, 0);
    queue_cmd(OP_WRITE, 9, 10, 1);        // horizontal blinker
    queue_cmd(OP_WRITE, 10, 10, 1);
    queue_cmd(OP_WRITE, 11, 10, 1);
    queue_cmd(OP_ADVANCE, 63, 63, 1);
    queue_cmd(OP_READ, 0, 0, 0);          // lone cell died
    queue_cmd(OP_READ, 10, 9, 0);         // blinker turned vertical
    queue_cmd(OP_READ, 9, 10, 0);
    queue_cmd(OP_WRITE, 10, 9, 0);        // write of a dead cell
    queue_cmd(OP_READ, 10, 9, 0);
    queue_cmd(OP_WRITE, 40, 40, 1);       // lives on outside a shrunken grid

    // zero width acts as one, oversized height clamps, toroidal
    set_config(0, 127, 1, int'(RST_BIRTH_MASK), int'(RST_SURVIVAL_MASK));
    queue_cmd(OP_READ, 40, 40, 0);        // off the grid in use
    queue_cmd(OP_WRITE, 1, 0, 1);
    queue_cmd(OP_READ, 0, 63, 0);

    // full grid again: the hidden cell kept its bit until the clear
    set_config(64, 64, 0, 511, 0);
    queue_cmd(OP_READ, 40, 40, 0);
    queue_cmd(OP_CLEAR, 63, 0, 1);
    queue_cmd(OP_READ, 40, 40, 1);

    // two-cell torus, neighbours alias onto themselves
    set_config(2, 1, 1, 'h0a4, 'h124);
    queue_cmd(OP_WRITE, 0, 0, 1);
    queue_cmd(OP_WRITE, 2, 0, 1);
    queue_cmd(OP_ADVANCE, 0, 0, 0);
    queue_cmd(OP_READ, 0, 0, 0);
    queue_cmd(OP_READ, 1, 0, 0);

    // random settings, each followed by a seed / evolve / read round;
    // every change of setting waits for the result side to empty
    while (n_queued < 700) begin
      quiet = ($urandom_range(0, 4) == 0);
      set_config(pick_size(), pick_size(), $urandom_range(0, 511), pick_mask(8), pick_mask(12));
      queue_phase();
    end

    wait_idle();
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

### life_like_automaton_step_core.f
hw/rtl/lla_pkg.sv
hw/rtl/lla_ram.sv
hw/rtl/lla_row_unit.sv
hw/rtl/life_like_automaton_step_core.sv
hw/rtl/lla_checker.sv
sim/tb_top.sv
